// File: src/bopf_pkg.sv
`timescale 1ns / 1ps
package bopf_pkg;

  localparam int MAX_BOXES  = 32;
  localparam int COORD_BITS = 16;
  localparam int KIND_W     = 4;
  localparam int ROW_LIMIT  = 32;
  localparam int MASK_W     = 32;
  localparam int IDX_W      = $clog2(ROW_LIMIT);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  // wide enough to hold both the box count and the row limit
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] y_end;
    logic [KIND_W-1:0]            kind;
  } box_t;

  typedef struct packed {
    logic load;   // store the broadcast box in this cell
    logic cmp;    // cell holds a box of the current set: test the new box
    logic shift;  // take the row of the next cell up
    logic clear;  // end of run: drop the row
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

endpackage

// File: src/bopf_box_if.sv
`timescale 1ns / 1ps
interface bopf_box_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bopf_pkg::COORD_BITS-1:0] x_start;
  logic signed [bopf_pkg::COORD_BITS-1:0] x_end;
  logic signed [bopf_pkg::COORD_BITS-1:0] y_start;
  logic signed [bopf_pkg::COORD_BITS-1:0] y_end;
  logic [bopf_pkg::KIND_W-1:0]            kind;
  logic                                   final_box;

  modport source (output valid, x_start, x_end, y_start, y_end, kind, final_box,
                  input ready);
  modport sink (input valid, x_start, x_end, y_start, y_end, kind, final_box,
                output ready);
endinterface

// File: src/bopf_row_if.sv
`timescale 1ns / 1ps
interface bopf_row_if;
  logic                         valid;
  logic                         ready;
  logic [bopf_pkg::IDX_W-1:0]   row_index;
  logic [bopf_pkg::MASK_W-1:0]  partner_mask;
  logic                         overflow;
  logic                         last_row;

  modport source (output valid, row_index, partner_mask, overflow, last_row,
                  input ready);
  modport sink (input valid, row_index, partner_mask, overflow, last_row,
                output ready);
endinterface

// File: src/bopf_cell.sv
`timescale 1ns / 1ps
module bopf_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bopf_pkg::cell_ctl_t               ctl_i,
  input  bopf_pkg::box_t                    box_i,
  input  logic [bopf_pkg::MAX_BOXES-1:0]    new_bit_i,
  input  logic [bopf_pkg::MAX_BOXES-1:0]    next_mask_i,
  output logic [bopf_pkg::MAX_BOXES-1:0]    mask_o
);

  bopf_pkg::box_t                  box_q;
  logic [bopf_pkg::MAX_BOXES-1:0]  mask_q, mask_d;
  logic                            x_meet, y_meet, hit;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      box_q <= box_i;
    end
  end

  // touching edges count as overlap
  always_comb begin
    x_meet = ($signed(box_q.x_start) <= $signed(box_i.x_end)) &&
             ($signed(box_i.x_start) <= $signed(box_q.x_end));
    y_meet = ($signed(box_q.y_start) <= $signed(box_i.y_end)) &&
             ($signed(box_i.y_start) <= $signed(box_q.y_end));
    hit    = ctl_i.cmp && (box_q.kind != box_i.kind) && x_meet && y_meet;
  end

  always_comb begin
    mask_d = mask_q;
    if (ctl_i.clear) begin
      mask_d = '0;
    end else if (ctl_i.shift) begin
      mask_d = next_mask_i;
    end else if (hit) begin
      mask_d = mask_q | new_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  assign mask_o = mask_q;

endmodule

// File: src/box_overlap_pair_finder_top.sv
`timescale 1ns / 1ps
// Broad-phase box overlap pair finder. Boxes are taken one per cycle; each is
// broadcast to a chain of cells, one per stored box, which test it against
// their own box in parallel and record a partner bit. Boxes beyond the chain
// length are dropped and flagged in overflow. The box carrying final_box is
// stored too, then rows are shifted out of the chain from cell 0, one per
// cycle that the sink takes, min(box count, 32) rows in all; no box is taken
// while rows are being emitted. The pair store is empty again when the last
// row leaves.
module box_overlap_pair_finder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  bopf_box_if.sink      box_i,
  bopf_row_if.source    row_o
);

  localparam int N = bopf_pkg::MAX_BOXES;

  bopf_pkg::state_e               state_q, state_d;
  logic [bopf_pkg::CNT_W-1:0]     count_q, count_d;
  logic                           drop_q, drop_d;
  logic [bopf_pkg::IDX_W-1:0]     row_q, row_d;
  logic [bopf_pkg::IDX_W-1:0]     last_idx_q, last_idx_d;

  logic                           in_acc, out_acc, full;
  logic                           shift, clear;
  logic [bopf_pkg::CMP_W-1:0]     count_after;
  logic [N-1:0]                   new_bit;
  logic [N-1:0]                   mask [N];
  bopf_pkg::box_t                 box;
  bopf_pkg::cell_ctl_t            ctl [N];

  assign box = '{x_start: box_i.x_start, x_end: box_i.x_end,
                 y_start: box_i.y_start, y_end: box_i.y_end,
                 kind: box_i.kind};

  assign box_i.ready = (state_q == bopf_pkg::ST_LOAD);
  assign in_acc      = box_i.valid && box_i.ready;
  assign out_acc     = row_o.valid && row_o.ready;
  assign full        = (count_q == bopf_pkg::CNT_W'(N));

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign new_bit[i]   = (count_q == bopf_pkg::CNT_W'(i));
    assign ctl[i].load  = in_acc && new_bit[i];
    assign ctl[i].cmp   = in_acc && (bopf_pkg::CNT_W'(i) < count_q);
    assign ctl[i].shift = shift;
    assign ctl[i].clear = clear;

    if (i == N - 1) begin : g_end
      bopf_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl[i]), .box_i(box), .new_bit_i(new_bit),
        .next_mask_i('0), .mask_o(mask[i])
      );
    end else begin : g_mid
      bopf_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl[i]), .box_i(box), .new_bit_i(new_bit),
        .next_mask_i(mask[i+1]), .mask_o(mask[i])
      );
    end
  end

  // boxes in the set once this item is stored
  assign count_after = bopf_pkg::CMP_W'(count_q) +
                       bopf_pkg::CMP_W'(!full);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    drop_d     = drop_q;
    row_d      = row_q;
    last_idx_d = last_idx_q;
    shift      = 1'b0;
    clear      = 1'b0;
    case (state_q)
      bopf_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
          if (box_i.final_box) begin
            state_d = bopf_pkg::ST_EMIT;
            row_d   = '0;
            if (count_after > bopf_pkg::CMP_W'(bopf_pkg::ROW_LIMIT)) begin
              last_idx_d = bopf_pkg::IDX_W'(bopf_pkg::ROW_LIMIT - 1);
            end else begin
              last_idx_d = bopf_pkg::IDX_W'(count_after - 1'b1);
            end
          end
        end
      end
      bopf_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (row_q == last_idx_q) begin
            clear   = 1'b1;
            count_d = '0;
            drop_d  = 1'b0;
            state_d = bopf_pkg::ST_LOAD;
          end else begin
            shift = 1'b1;
            row_d = row_q + 1'b1;
          end
        end
      end
      default: state_d = bopf_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bopf_pkg::ST_LOAD;
      count_q    <= '0;
      drop_q     <= 1'b0;
      row_q      <= '0;
      last_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      row_q      <= row_d;
      last_idx_q <= last_idx_d;
    end
  end

  assign row_o.valid     = (state_q == bopf_pkg::ST_EMIT);
  assign row_o.row_index = row_q;
  assign row_o.overflow  = drop_q;
  assign row_o.last_row  = (row_q == last_idx_q);

  if (N >= bopf_pkg::MASK_W) begin : g_mask_wide
    assign row_o.partner_mask = mask[0][bopf_pkg::MASK_W-1:0];
  end else begin : g_mask_narrow
    assign row_o.partner_mask = bopf_pkg::MASK_W'(mask[0]);
  end

endmodule
